// ----- src/sha512_pkg.sv -----
// ----------------------------------------------------------------------------
// sha512_pkg
// types, constants and a rotate helper shared by the sha-512 core
// ----------------------------------------------------------------------------
package sha512_pkg;

  localparam int unsigned WordW   = 64;
  localparam int unsigned Rounds  = 80;
  localparam int unsigned BlkWords = 16;

  typedef struct packed {
    logic [63:0] message_word;
    logic [3:0]  valid_bytes;
    logic        last_word;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_done;
  } out_item_t;

  // control from the sequencer to the round unit
  typedef struct packed {
    logic       start;
    logic       step;
    logic [6:0] round;
    logic       finish;
  } rnd_ctrl_t;

  localparam logic [63:0] InitHash [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
    64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam logic [63:0] RoundK [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f,
    64'he9b5dba58189dbbc, 64'h3956c25bf348b538, 64'h59f111f1b605d019,
    64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118, 64'hd807aa98a3030242,
    64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235,
    64'hc19bf174cf692694, 64'he49b69c19ef14ad2, 64'hefbe4786384f25e3,
    64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65, 64'h2de92c6f592b0275,
    64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f,
    64'hbf597fc7beef0ee4, 64'hc6e00bf33da88fc2, 64'hd5a79147930aa725,
    64'h06ca6351e003826f, 64'h142929670a0e6e70, 64'h27b70a8546d22ffc,
    64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6,
    64'h92722c851482353b, 64'ha2bfe8a14cf10364, 64'ha81a664bbc423001,
    64'hc24b8b70d0f89791, 64'hc76c51a30654be30, 64'hd192e819d6ef5218,
    64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99,
    64'h34b0bcb5e19b48a8, 64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb,
    64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3, 64'h748f82ee5defb2fc,
    64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915,
    64'hc67178f2e372532b, 64'hca273eceea26619c, 64'hd186b8c721c0c207,
    64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178, 64'h06f067aa72176fba,
    64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc,
    64'h431d67c49c100d4c, 64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a,
    64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction

endpackage

// ----- src/sha512_round.sv -----
// ----------------------------------------------------------------------------
// sha512_round
// one compression round per cycle while step is asserted, over a 16-word schedule window
// ----------------------------------------------------------------------------
module sha512_round (
  input  logic                   clk_i,
  input  sha512_pkg::rnd_ctrl_t  ctrl_i,
  input  logic [63:0]            blk_i [16],
  input  logic [63:0]            hash_i [8],
  output logic [63:0]            hash_o [8]
);
  import sha512_pkg::*;

  logic [63:0] w_q [16];
  logic [63:0] v_q [8];
  logic [63:0] w_t, w_new, s0, s1, t1, t2;
  logic [3:0]  idx;

  assign idx = ctrl_i.round[3:0];

  always_comb begin
    s1 = rotr(w_q[idx - 4'd2], 19) ^ rotr(w_q[idx - 4'd2], 61) ^ (w_q[idx - 4'd2] >> 6);
    s0 = rotr(w_q[idx - 4'd15], 1) ^ rotr(w_q[idx - 4'd15], 8) ^ (w_q[idx - 4'd15] >> 7);
    w_new = s1 + w_q[idx - 4'd7] + s0 + w_q[idx];
    w_t = (ctrl_i.round >= 7'd16) ? w_new : w_q[idx];
    t1 = v_q[7] + (rotr(v_q[4], 14) ^ rotr(v_q[4], 18) ^ rotr(v_q[4], 41))
         + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + RoundK[ctrl_i.round] + w_t;
    t2 = (rotr(v_q[0], 28) ^ rotr(v_q[0], 34) ^ rotr(v_q[0], 39))
         + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      w_q <= blk_i;
      v_q <= hash_i;
    end else if (ctrl_i.step) begin
      w_q[idx] <= w_t;
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  // chaining add, used on the cycle after the last round
  always_comb begin
    for (int i = 0; i < 8; i++) hash_o[i] = hash_i[i] + v_q[i];
  end

endmodule

// ----- src/sha512_hash_core.sv -----
// ----------------------------------------------------------------------------
// sha512_hash_core
// sha-512 digest over big-endian 64-bit message words
// ----------------------------------------------------------------------------
// channel   dir  handshake              payload
// in        in   in_valid_i/in_ready_o  sha512_pkg::in_item_t
// out       out  out_valid_o/out_ready_i sha512_pkg::out_item_t
//
// a word that does not fill a block and is not the last is stored; in_ready_o stays high
// the sixteenth word of a block runs: accept, setup, 80 rounds, chaining add
// a last word inserts padding words one per cycle, compresses one or two blocks,
// then offers eight digest words
// reset restores the initial hash values; out_ready_i low holds the digest word
module sha512_hash_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  sha512_pkg::in_item_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output sha512_pkg::out_item_t out_data_o
);
  import sha512_pkg::*;

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StPad  = 5'b00010,
    StInit = 5'b00100,
    StRnd  = 5'b01000,
    StOut  = 5'b10000
  } state_e;

  state_e      state_q, state_d;
  logic [63:0] hash_q [8];
  logic [63:0] hash_sum [8];
  logic [63:0] blk_q [16];
  logic [3:0]  wcnt_q;
  logic [127:0] len_q;
  logic [6:0]  rnd_q;
  logic [2:0]  oidx_q;
  logic        fin_q;   // full eight-byte last word still owes its 0x80 word
  logic        lenw_q;  // low length word is next
  rnd_ctrl_t   ctrl;

  logic        push;
  logic [63:0] push_word;
  logic [3:0]  cnt;
  logic [63:0] mask, padw;
  logic        acc;

  assign acc = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == StIdle);
  assign cnt = (in_data_i.valid_bytes > 4'd8) ? 4'd8 : in_data_i.valid_bytes;

  always_comb begin
    mask = (cnt == 4'd0) ? 64'd0 : ~(64'hffff_ffff_ffff_ffff >> {cnt[3:0], 3'b000});
    padw = (in_data_i.message_word & mask) | (64'h80 << (7'd56 - {cnt[2:0], 3'b000}));
    if (cnt == 4'd8) padw = in_data_i.message_word;
  end

  // word fed to the buffer this cycle
  always_comb begin
    push = 1'b0;
    push_word = 64'd0;
    if (acc) begin
      push = 1'b1;
      push_word = in_data_i.last_word ? padw : in_data_i.message_word;
    end else if (state_q == StPad) begin
      push = 1'b1;
      if (lenw_q && wcnt_q == 4'd15) push_word = len_q[63:0];
      else if (!lenw_q && wcnt_q == 4'd14 && !fin_q) push_word = len_q[127:64];
      else if (fin_q) push_word = 64'h8000_0000_0000_0000;
      else push_word = 64'd0;
    end
  end

  assign ctrl.start  = (state_q == StInit);
  assign ctrl.step   = (state_q == StRnd) && (rnd_q < 7'd80);
  assign ctrl.round  = (rnd_q < 7'd80) ? rnd_q : 7'd0;
  assign ctrl.finish = (state_q == StRnd) && (rnd_q == 7'd80);

  sha512_round u_round (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .blk_i  (blk_q),
    .hash_i (hash_q),
    .hash_o (hash_sum)
  );

  // fin_q: a full eight-byte last word still owes its 0x80 word
  logic pad_d;
  logic pad_q;  // padding (after last word) pending; after rounds, resume at StPad or offer the digest

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (acc) begin
        if (wcnt_q == 4'd15) state_d = StInit;
        else if (in_data_i.last_word) state_d = StPad;
      end
      StPad:  if (wcnt_q == 4'd15) state_d = StInit;
      StInit: state_d = StRnd;
      StRnd:  if (ctrl.finish) state_d = pad_q ? (lenw_q ? StOut : StPad) : StIdle;
      StOut:  if (out_ready_i && oidx_q == 3'd7) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    pad_d = pad_q;
    if (acc && in_data_i.last_word) pad_d = 1'b1;
    if (state_q == StOut && out_ready_i && oidx_q == 3'd7) pad_d = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (push) blk_q[wcnt_q] <= push_word;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      wcnt_q  <= '0;
      len_q   <= '0;
      rnd_q   <= '0;
      oidx_q  <= '0;
      fin_q   <= 1'b0;
      lenw_q  <= 1'b0;
      pad_q   <= 1'b0;
      for (int i = 0; i < 8; i++) hash_q[i] <= InitHash[i];
    end else begin
      state_q <= state_d;
      pad_q   <= pad_d;
      if (push) wcnt_q <= wcnt_q + 4'd1;
      if (acc) begin
        len_q  <= len_q + (in_data_i.last_word ? {121'd0, cnt, 3'b000} : 128'd64);
        fin_q  <= in_data_i.last_word && (cnt == 4'd8);
      end else if (state_q == StPad) begin
        if (fin_q) fin_q <= 1'b0;
        else if (wcnt_q == 4'd14) lenw_q <= 1'b1;
      end
      if (state_q == StInit) rnd_q <= '0;
      else if (ctrl.step) rnd_q <= rnd_q + 7'd1;
      if (ctrl.finish) hash_q <= hash_sum;
      if (state_q == StOut && out_ready_i) begin
        oidx_q <= oidx_q + 3'd1;
        if (oidx_q == 3'd7) begin
          for (int i = 0; i < 8; i++) hash_q[i] <= InitHash[i];
          len_q  <= '0;
          lenw_q <= 1'b0;
          wcnt_q <= '0;
        end
      end
    end
  end

  assign out_valid_o = (state_q == StOut);
  assign out_data_o.digest_word = hash_q[oidx_q];
  assign out_data_o.word_index  = oidx_q;
  assign out_data_o.digest_done = (oidx_q == 3'd7);

  // no input transaction while a block compresses
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRnd) |-> !in_ready_o) else $error("input taken during rounds");
  // round counter never runs past the last round
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rnd_q <= 7'd80) else $error("round counter overflow");
  // digest is only offered after padding started
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pad_q) else $error("digest without last word");
  // digest index starts at zero when offering begins
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> oidx_q == 3'd0) else $error("digest index not reset");

endmodule
